>>> hdl/ili_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ili_pkg: shared types and codes for the indexed list
// Default sizes, command and status codes, channel payloads and the
// per-cell control group.
// ----------------------------------------------------------------------------
package ili_pkg;

  // default sizes
  localparam int ILI_DEPTH     = 64;
  localparam int ILI_WORD_BITS = 32;

  // fixed field widths
  localparam int FUNC_BITS   = 3;
  localparam int POS_BITS    = 6;
  localparam int DATA_BITS   = 32;
  localparam int COUNT_BITS  = 7;
  localparam int STATUS_BITS = 2;

  // command codes
  localparam logic [FUNC_BITS-1:0] FN_PUSH   = 3'd0;
  localparam logic [FUNC_BITS-1:0] FN_POP    = 3'd1;
  localparam logic [FUNC_BITS-1:0] FN_INSERT = 3'd2;
  localparam logic [FUNC_BITS-1:0] FN_ERASE  = 3'd3;
  localparam logic [FUNC_BITS-1:0] FN_GET    = 3'd4;
  localparam logic [FUNC_BITS-1:0] FN_SET    = 3'd5;

  // status codes
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd3;

  // command item
  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic [POS_BITS-1:0]  position;
    logic [DATA_BITS-1:0] word_in;
  } ili_cmd_t;

  // result item
  typedef struct packed {
    logic [DATA_BITS-1:0]   word_out;
    logic [COUNT_BITS-1:0]  count;
    logic                   is_empty;
    logic [STATUS_BITS-1:0] status;
  } ili_rsp_t;

  // per-cell control for one cycle
  typedef struct packed {
    logic load;        // take the command word
    logic take_lower;  // take the word of the cell below (insert shift)
    logic take_upper;  // take the word of the cell above (erase shift)
    logic rd_hit;      // drive the read bus
  } ili_cell_ctrl_t;

endpackage

>>> hdl/ili_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ili_cmd_if: command channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface ili_cmd_if;
  import ili_pkg::*;

  logic     valid;
  logic     ready;
  ili_cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/ili_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ili_rsp_if: result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface ili_rsp_if;
  import ili_pkg::*;

  logic     valid;
  logic     ready;
  ili_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/ili_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ili_cell: one list entry
// Holds one word; loads, shifts from a neighbor or holds, and drives
// the shared read bus when selected.
// ----------------------------------------------------------------------------
module ili_cell #(
  parameter int WORD_BITS = 32
) (
  input  logic                    clk,
  input  ili_pkg::ili_cell_ctrl_t ctrl,
  input  logic [WORD_BITS-1:0]    wr_word,
  input  logic [WORD_BITS-1:0]    lower_word,
  input  logic [WORD_BITS-1:0]    upper_word,
  output logic [WORD_BITS-1:0]    word,
  output logic [WORD_BITS-1:0]    rd_term
);
  import ili_pkg::*;

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;

  // next value: load wins, then the shift sources
  always_comb begin
    priority if (ctrl.load) begin
      word_nxt = wr_word;
    end else if (ctrl.take_lower) begin
      word_nxt = lower_word;
    end else if (ctrl.take_upper) begin
      word_nxt = upper_word;
    end else begin
      word_nxt = word_r;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word    = word_r;
  assign rd_term = ctrl.rd_hit ? word_r : '0;

endmodule

>>> hdl/indexed_list_insert_erase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_erase: ordered word list with insert and erase
// A row of entry cells shifting toward a neighbor, plus the count and
// command decode. Push, pop, insert, erase, get and set.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake          payload
//   in_ch     in    valid / ready      func, position, word_in
//   out_ch    out   valid / ready      word_out, count, is_empty, status
//
// One item per cycle while out_ch does not stall: every cell shifts, loads
// or holds in the cycle the command is taken, and the result is registered
// for the next cycle. The read word comes from the pre-update cell contents
// over the cell bus. Reset clears the count and the result valid flag;
// entries and result fields stay undefined. While a result waits on out_ch,
// a new item is taken only in the cycle that result is taken.
// ----------------------------------------------------------------------------
module indexed_list_insert_erase #(
  parameter int DEPTH     = ili_pkg::ILI_DEPTH,
  parameter int WORD_BITS = ili_pkg::ILI_WORD_BITS
) (
  input  logic    clk,
  input  logic    rst_n,
  ili_cmd_if.sink   in_ch,
  ili_rsp_if.source out_ch
);
  import ili_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_BITS) ? CW : POS_BITS;

  logic [CW-1:0] held_r;
  logic [CW-1:0] held_nxt;

  logic [DATA_BITS-1:0]   word_out_r;
  logic [COUNT_BITS-1:0]  count_r;
  logic                   is_empty_r;
  logic [STATUS_BITS-1:0] status_r;
  logic                   out_valid_r;

  logic in_ready;
  logic acc;

  logic is_full;
  logic is_none;
  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] held_x;
  logic [CMPW-1:0] held_dec;

  logic do_push, do_pop, do_ins, do_ers, do_get, do_set;
  logic [STATUS_BITS-1:0] st;

  logic [WORD_BITS-1:0] wr_word;
  logic [WORD_BITS-1:0] cell_word [DEPTH];
  logic [WORD_BITS-1:0] rd_term   [DEPTH];
  logic [WORD_BITS-1:0] rd_bus;

  // handshake
  assign in_ready    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;
  assign acc         = in_ch.valid && in_ready;

  assign is_full  = (held_r == CW'(DEPTH));
  assign is_none  = (held_r == '0);
  assign pos_x    = CMPW'(in_ch.data.position);
  assign held_x   = CMPW'(held_r);
  assign held_dec = held_x - CMPW'(1);
  assign wr_word  = WORD_BITS'(in_ch.data.word_in);

  // command decode and new count
  always_comb begin
    do_push  = 1'b0;
    do_pop   = 1'b0;
    do_ins   = 1'b0;
    do_ers   = 1'b0;
    do_get   = 1'b0;
    do_set   = 1'b0;
    st       = ST_OK;
    held_nxt = held_r;
    unique case (in_ch.data.func)
      FN_PUSH: begin
        if (is_full) begin
          st = ST_FULL;
        end else begin
          do_push  = acc;
          held_nxt = held_r + CW'(1);
        end
      end
      FN_POP: begin
        if (is_none) begin
          st = ST_EMPTY;
        end else begin
          do_pop   = acc;
          held_nxt = held_r - CW'(1);
        end
      end
      FN_INSERT: begin
        if (is_full) begin
          st = ST_FULL;
        end else if (pos_x > held_x) begin
          st = ST_RANGE;
        end else begin
          do_ins   = acc;
          held_nxt = held_r + CW'(1);
        end
      end
      FN_ERASE, FN_GET, FN_SET: begin
        if (is_none) begin
          st = ST_EMPTY;
        end else if (pos_x >= held_x) begin
          st = ST_RANGE;
        end else if (in_ch.data.func == FN_ERASE) begin
          do_ers   = acc;
          held_nxt = held_r - CW'(1);
        end else if (in_ch.data.func == FN_GET) begin
          do_get = acc;
        end else begin
          do_set = acc;
        end
      end
      default: begin
      end
    endcase
  end

  // row of entry cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ili_cell_ctrl_t       ctrl;
    logic [WORD_BITS-1:0] lower_word;
    logic [WORD_BITS-1:0] upper_word;

    assign ctrl.load       = (do_push && (CMPW'(i) == held_x)) ||
                             ((do_ins || do_set) && (CMPW'(i) == pos_x));
    assign ctrl.take_lower = do_ins && (CMPW'(i) > pos_x);
    assign ctrl.take_upper = do_ers && (CMPW'(i) >= pos_x);
    assign ctrl.rd_hit     = (do_pop && (CMPW'(i) == held_dec)) ||
                             ((do_ers || do_get) && (CMPW'(i) == pos_x));

    if (i == 0) begin : g_lo0
      assign lower_word = '0;
    end else begin : g_lo
      assign lower_word = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_hi0
      assign upper_word = '0;
    end else begin : g_hi
      assign upper_word = cell_word[i+1];
    end

    ili_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .wr_word    (wr_word),
      .lower_word (lower_word),
      .upper_word (upper_word),
      .word       (cell_word[i]),
      .rd_term    (rd_term[i])
    );
  end

  // read bus: at most one cell drives it
  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_bus = rd_bus | rd_term[k];
    end
  end

  // count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (acc) begin
      held_r <= held_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      word_out_r <= DATA_BITS'(rd_bus);
      count_r    <= COUNT_BITS'(held_nxt);
      is_empty_r <= (held_nxt == '0);
      status_r   <= st;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.data.word_out = word_out_r;
  assign out_ch.data.count    = count_r;
  assign out_ch.data.is_empty = is_empty_r;
  assign out_ch.data.status   = status_r;

  // checks
  a_held_stable : assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(held_r))
    else $error("count changed without a command");

  a_push_grows : assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_ch.data.func == FN_PUSH) && !is_full |=> held_r == $past(held_r) + CW'(1))
    else $error("push did not grow the list");

  a_held_bound : assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(DEPTH))
    else $error("count beyond depth");

  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != ST_OK) |-> word_out_r == '0)
    else $error("error result carries a word");

  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid_r)
    else $error("accepted item gave no result");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for indexed_list_insert_erase
// Drives commands and takes results over the valid/ready channels. A
// scoreboard class holds its own copy of the word list. It works out the
// expected result of every accepted command and checks each accepted result
// against the oldest one still owed. A short directed run covers the empty
// and range errors, the ignored codes and the extreme words. Random phases
// then grow, shrink or churn the list, which drives it to full and back to
// empty many times.
// ----------------------------------------------------------------------------
module tb_top;
  import ili_pkg::*;

  // func codes the block ignores
  localparam logic [FUNC_BITS-1:0] FN_SPARE_LO = 3'd6;
  localparam logic [FUNC_BITS-1:0] FN_SPARE_HI = 3'd7;

  // random phase flavors
  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_CHURN} phase_mode_t;

  localparam int RAND_ITEMS  = 1830;
  localparam int STALL_LIMIT = 2000;  // cycles with no item moving
  localparam int DRAIN_WAIT  = 8;

  // --------------------------------------------------------------------------
  // Scoreboard: list model plus the queue of results still owed
  // --------------------------------------------------------------------------
  class list_scoreboard;
    logic [DATA_BITS-1:0] cells[ILI_DEPTH];
    int unsigned          held = 0;
    ili_rsp_t             owed[$];
    int unsigned          errors = 0;

    task report(string what, logic [DATA_BITS-1:0] got, logic [DATA_BITS-1:0] want);
      $display("[%0t] mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
      errors++;
    endtask

    // apply one accepted command to the list and queue its result
    function void note_cmd(ili_cmd_t c);
      ili_rsp_t             r;
      logic [DATA_BITS-1:0] rd;
      logic [1:0]           st;
      int unsigned          pos;
      rd  = '0;
      st  = ST_OK;
      pos = c.position;
      case (c.func)
        FN_PUSH: begin
          if (held >= ILI_DEPTH) st = ST_FULL;
          else begin
            cells[held] = c.word_in;
            held++;
          end
        end
        FN_POP: begin
          if (held == 0) st = ST_EMPTY;
          else begin
            held--;
            rd = cells[held];
          end
        end
        FN_INSERT: begin
          if (held >= ILI_DEPTH) st = ST_FULL;
          else if (pos > held) st = ST_RANGE;
          else begin
            for (int i = held; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = c.word_in;
            held++;
          end
        end
        FN_ERASE, FN_GET, FN_SET: begin
          if (held == 0) st = ST_EMPTY;
          else if (pos >= held) st = ST_RANGE;
          else if (c.func == FN_ERASE) begin
            rd = cells[pos];
            held--;
            for (int i = pos; i < held; i++) cells[i] = cells[i+1];
          end else if (c.func == FN_GET) begin
            rd = cells[pos];
          end else begin
            cells[pos] = c.word_in;
          end
        end
        default: ;  // spare codes leave the list alone
      endcase
      r.word_out = rd;
      r.count    = held[COUNT_BITS-1:0];
      r.is_empty = (held == 0);
      r.status   = st;
      owed.push_back(r);
    endfunction

    // compare one accepted result with the oldest expectation
    task check_rsp(ili_rsp_t r);
      ili_rsp_t e;
      if (owed.size() == 0) begin
        report("result with nothing owed, word_out", r.word_out, '0);
        return;
      end
      e = owed.pop_front();
      if (r.word_out !== e.word_out) report("word_out", r.word_out, e.word_out);
      if (r.count !== e.count)       report("count", 32'(r.count), 32'(e.count));
      if (r.is_empty !== e.is_empty) report("is_empty", 32'(r.is_empty), 32'(e.is_empty));
      if (r.status !== e.status)     report("status", 32'(r.status), 32'(e.status));
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   no_idle;
  int   quiet_cycles;

  list_scoreboard sb;

  ili_cmd_if cmd_if ();
  ili_rsp_if rsp_if ();

  indexed_list_insert_erase u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_if),
    .out_ch (rsp_if)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side back-pressure, one decision per falling edge
  always @(negedge clk) begin
    rsp_if.ready <= no_idle || ($urandom_range(0, 99) >= 25);
  end

  // monitor: check results, then record commands, plus the stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) sb.check_rsp(rsp_if.data);
      if (cmd_if.valid && cmd_if.ready) sb.note_cmd(cmd_if.data);
      if ((rsp_if.valid && rsp_if.ready) || (cmd_if.valid && cmd_if.ready))
        quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic ili_cmd_t mk_cmd(logic [FUNC_BITS-1:0] f, int unsigned p,
                                      logic [DATA_BITS-1:0] w);
    ili_cmd_t c;
    c.func     = f;
    c.position = p[POS_BITS-1:0];
    c.word_in  = w;
    return c;
  endfunction

  function automatic logic [DATA_BITS-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'(1) << $urandom_range(0, DATA_BITS - 1);
      default: return $urandom;
    endcase
  endfunction

  // mostly legal indexes, sometimes anything the field allows
  function automatic int unsigned pick_index(logic [FUNC_BITS-1:0] f);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (f == FN_INSERT) begin
      if (r < 15) return (sb.held < 64) ? sb.held : $urandom_range(0, 63);
      if (r < 85) return $urandom_range(0, (sb.held < 63) ? sb.held : 63);
    end else if (sb.held > 0 && r < 85) begin
      return $urandom_range(0, sb.held - 1);
    end
    return $urandom_range(0, 63);
  endfunction

  function automatic ili_cmd_t pick_cmd(phase_mode_t mode);
    logic [FUNC_BITS-1:0] f;
    int unsigned          r;
    r = $urandom_range(0, 99);
    if (r < 3) f = r[0] ? FN_SPARE_HI : FN_SPARE_LO;
    else begin
      case (mode)
        MODE_GROW: begin
          if (r < 38)      f = FN_PUSH;
          else if (r < 73) f = FN_INSERT;
          else if (r < 83) f = FN_GET;
          else if (r < 93) f = FN_SET;
          else             f = r[0] ? FN_POP : FN_ERASE;
        end
        MODE_SHRINK: begin
          if (r < 38)      f = FN_POP;
          else if (r < 73) f = FN_ERASE;
          else if (r < 83) f = FN_GET;
          else if (r < 93) f = FN_SET;
          else             f = r[0] ? FN_PUSH : FN_INSERT;
        end
        default: f = FUNC_BITS'($urandom_range(0, 5));
      endcase
    end
    return mk_cmd(f, pick_index(f), pick_word());
  endfunction

  // offer one item, with random gaps ahead of it, and hold until taken
  task drive_cmd(ili_cmd_t c);
    while (!no_idle && $urandom_range(0, 99) < 25) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= c;
    do @(posedge clk); while (!(cmd_if.valid && cmd_if.ready));
    @(negedge clk);
  endtask

  initial begin
    phase_mode_t mode;
    int          span;
    int          sent;
    sb           = new;
    clk          = 1'b0;
    rst_n        = 1'b0;
    no_idle      = 1'b0;
    quiet_cycles = 0;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    rsp_if.ready = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: errors on an empty list
    drive_cmd(mk_cmd(FN_POP,    0,  '0));
    drive_cmd(mk_cmd(FN_ERASE,  0,  '0));
    drive_cmd(mk_cmd(FN_GET,    0,  '0));
    drive_cmd(mk_cmd(FN_SET,    0,  '1));
    drive_cmd(mk_cmd(FN_INSERT, 1,  '1));  // past the count
    // build a short list: insert at the count appends
    drive_cmd(mk_cmd(FN_INSERT, 0,  '1));
    drive_cmd(mk_cmd(FN_PUSH,   0,  '0));
    drive_cmd(mk_cmd(FN_PUSH,   63, 32'hA5A5_5A5A));
    drive_cmd(mk_cmd(FN_INSERT, 1,  32'h1234_5678));
    drive_cmd(mk_cmd(FN_INSERT, 4,  32'h8000_0001));
    drive_cmd(mk_cmd(FN_INSERT, 63, '1));
    // reads at both ends and out of range, then writes in and out of range
    drive_cmd(mk_cmd(FN_GET,    0,  '0));
    drive_cmd(mk_cmd(FN_GET,    4,  '0));
    drive_cmd(mk_cmd(FN_GET,    5,  '0));
    drive_cmd(mk_cmd(FN_GET,    63, '0));
    drive_cmd(mk_cmd(FN_SET,    2,  '1));
    drive_cmd(mk_cmd(FN_SET,    63, '1));
    // erase in the middle, at the end, and out of range
    drive_cmd(mk_cmd(FN_ERASE,  1,  '0));
    drive_cmd(mk_cmd(FN_ERASE,  3,  '0));
    drive_cmd(mk_cmd(FN_ERASE,  63, '0));
    // spare codes are ignored
    drive_cmd(mk_cmd(FN_SPARE_LO, 63, '1));
    drive_cmd(mk_cmd(FN_SPARE_HI, 0,  '1));
    drive_cmd(mk_cmd(FN_POP,    0,  '0));
    drive_cmd(mk_cmd(FN_GET,    2,  '0));

    // random phases; one long window runs with no gaps on either side
    sent = 0;
    while (sent < RAND_ITEMS) begin
      mode = phase_mode_t'($urandom_range(0, 2));
      span = $urandom_range(20, 90);
      for (int k = 0; k < span && sent < RAND_ITEMS; k++) begin
        no_idle = (sent >= 700 && sent < 1000);
        drive_cmd(pick_cmd(mode));
        sent++;
      end
    end
    no_idle = 1'b0;
    cmd_if.valid <= 1'b0;

    // drain, then a short quiet spell to catch stray results
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> indexed_list_insert_erase.f
hdl/ili_pkg.sv
hdl/ili_cmd_if.sv
hdl/ili_rsp_if.sv
hdl/ili_cell.sv
hdl/indexed_list_insert_erase.sv
dv/tb_top.sv
